FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the PT100 temperature loop
// Clocked assertions on aclk; compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked outside reset only
`define PTL_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define PTL_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define PTL_ASSERT(name, prop, msg)
`define PTL_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

FILE: sv/ptl_pkg.sv
// ----------------------------------------------------------------------------
// ptl_pkg
// Types and constants shared by the PT100 temperature loop modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ptl_pkg;

    localparam int ADC_BITS    = 10;
    localparam int TEMP_BITS   = 7;
    localparam int DUTY_BITS   = 8;
    localparam int GAIN_BITS   = 8;
    localparam int ERR_BITS    = 8;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_SETPOINT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_S0  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_S1  = 2'd2;

    localparam logic [TEMP_BITS-1:0]  RST_SETPOINT = 7'd0;
    localparam logic signed [GAIN_BITS-1:0] RST_GAIN_S0 = 8'sd6;
    localparam logic signed [GAIN_BITS-1:0] RST_GAIN_S1 = -8'sd3;

    // conversion constants
    localparam logic [ADC_BITS:0] ADC_FULL   = 11'd1024;
    localparam logic [13:0]       R_OFFSET   = 14'd12769;
    // floor(x/25) = (x * 41944) >> 20 for x < 43690
    localparam logic [15:0]       RECIP_25   = 16'd41944;
    localparam int                SHIFT_25   = 20;
    // floor(x/125) = (x * 134218) >> 24 for x < 493000
    localparam logic [17:0]       RECIP_125  = 18'd134218;
    localparam int                SHIFT_125  = 24;
    localparam logic [9:0]        T_OFFSET   = 10'd260;
    localparam logic [9:0]        T_SAT_HIGH = 10'd387;   // 260 + 127

    localparam logic [DUTY_BITS-1:0] DUTY_MAX = 8'd255;

    typedef struct packed {
        logic [TEMP_BITS-1:0]         setpoint;
        logic signed [GAIN_BITS-1:0]  gain_s0;
        logic signed [GAIN_BITS-1:0]  gain_s1;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

FILE: sv/pt100_pi_temperature_loop.sv
// ----------------------------------------------------------------------------
// pt100_pi_temperature_loop
// PT100 temperature measurement with an incremental PI controller.
// ----------------------------------------------------------------------------
// Each 10-bit ADC sample is turned into whole degrees (0..127) by a front end
// (two constant reciprocal multiplies with registers between them), passed
// through a two-entry queue, and a back end runs the PI step
// u = acc + gain_s0*e + gain_s1*e_prev, keeps the saturated u as the new
// accumulator and returns the duty clamped to 0..255 with the temperature, the
// peak since reset and the error. The front end takes no new sample until it
// has pushed the last one into the queue. Setpoint and gains are written
// through cfg_wr_en/cfg_index/cfg_wdata; the user must do so only while the
// block is idle; the block does not enforce it. Indexes above two are ignored.
`default_nettype none

module pt100_pi_temperature_loop
    import ptl_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  wire logic                     s_valid,
    output      logic                     s_ready,
    input  wire logic [ADC_BITS-1:0]      s_adc_sample,
    output      logic                     m_valid,
    input  wire logic                     m_ready,
    output      logic [DUTY_BITS-1:0]     m_pwm_duty,
    output      logic [TEMP_BITS-1:0]     m_temperature,
    output      logic [TEMP_BITS-1:0]     m_max_temperature,
    output      logic [ERR_BITS-1:0]      m_control_error
);

    cfg_t          cfg_reg;
    queue_status_t q_status;
    logic                 q_push, q_pop;
    logic [TEMP_BITS-1:0] q_push_data, q_pop_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.setpoint <= RST_SETPOINT;
            cfg_reg.gain_s0  <= RST_GAIN_S0;
            cfg_reg.gain_s1  <= RST_GAIN_S1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SETPOINT: cfg_reg.setpoint <= cfg_wdata[TEMP_BITS-1:0];
                REG_GAIN_S0:  cfg_reg.gain_s0  <= $signed(cfg_wdata[GAIN_BITS-1:0]);
                REG_GAIN_S1:  cfg_reg.gain_s1  <= $signed(cfg_wdata[GAIN_BITS-1:0]);
                default: ;
            endcase
        end
    end

    ptl_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_adc_sample (s_adc_sample),
        .q_status     (q_status),
        .q_push       (q_push),
        .q_push_data  (q_push_data)
    );

    ptl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    ptl_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .q_status          (q_status),
        .q_pop_data        (q_pop_data),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pwm_duty        (m_pwm_duty),
        .m_temperature     (m_temperature),
        .m_max_temperature (m_max_temperature),
        .m_control_error   (m_control_error)
    );

endmodule

`default_nettype wire

FILE: sv/ptl_queue.sv
// ----------------------------------------------------------------------------
// ptl_queue
// Short FIFO of converted temperatures between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ptl_queue
    import ptl_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire logic [TEMP_BITS-1:0] push_data,
    input  wire logic                 pop,
    output      logic [TEMP_BITS-1:0] pop_data,
    output      queue_status_t        status
);

    logic [TEMP_BITS-1:0]      mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg, count_next;
    logic                      do_push, do_pop;

    assign status.full  = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `PTL_ASSERT(a_count_bound, count_reg <= QUEUE_CNT_BITS'(QUEUE_DEPTH), "queue count exceeds depth")
    `PTL_ASSERT(a_no_overflow, push |-> !status.full, "push into full queue")
    `PTL_ASSERT(a_no_underflow, pop |-> !status.empty, "pop from empty queue")

endmodule

`default_nettype wire

FILE: sv/ptl_front.sv
// ----------------------------------------------------------------------------
// ptl_front
// Takes ADC samples and converts each to whole degrees.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ptl_front
    import ptl_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output      logic                 s_ready,
    input  wire logic [ADC_BITS-1:0]  s_adc_sample,
    input  wire queue_status_t        q_status,
    output      logic                 q_push,
    output      logic [TEMP_BITS-1:0] q_push_data
);

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_RES   = 2'd1;
    localparam logic [1:0] F_SCALE = 2'd2;
    localparam logic [1:0] F_TEMP  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [14:0] x_reg;          // 31 * v
    logic [13:0] r_reg;          // resistance, hundredths of an ohm
    logic [17:0] y_reg;          // 13 * r

    logic [ADC_BITS:0] v;
    logic [14:0]       x_next;
    logic [30:0]       prod_25;
    logic [13:0]       r_next;
    logic [17:0]       y_next;
    logic [33:0]       prod_125;
    logic [9:0]        z;

    assign s_ready = (state_reg == F_IDLE);

    assign v       = ADC_FULL - {1'b0, s_adc_sample};
    assign x_next  = (15'(v) << 5) - 15'(v);
    assign prod_25 = {16'd0, x_reg} * {15'd0, RECIP_25};
    assign r_next  = R_OFFSET - {3'd0, prod_25[SHIFT_25 +: 11]};
    assign y_next  = (18'(r_reg) << 3) + (18'(r_reg) << 2) + 18'(r_reg);
    assign prod_125 = {18'd0, y_reg[17:2]} * {16'd0, RECIP_125};
    assign z       = prod_125[SHIFT_125 +: 10];

    always_comb begin
        if (z < T_OFFSET) begin
            q_push_data = '0;
        end else if (z > T_SAT_HIGH) begin
            q_push_data = '1;
        end else begin
            q_push_data = TEMP_BITS'(z - T_OFFSET);
        end
    end

    assign q_push = (state_reg == F_TEMP) && !q_status.full;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    state_next = F_RES;
                end
            end
            F_RES:   state_next = F_SCALE;
            F_SCALE: state_next = F_TEMP;
            F_TEMP: begin
                if (!q_status.full) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            x_reg <= x_next;
        end
        if (state_reg == F_RES) begin
            r_reg <= r_next;
        end
        if (state_reg == F_SCALE) begin
            y_reg <= y_next;
        end
    end

    `PTL_ASSERT(a_push_only_in_temp, q_push |-> state_reg == F_TEMP, "push outside final step")
    `PTL_ASSERT(a_transfer_starts_work, (s_valid && s_ready) |=> state_reg == F_RES, "sample transfer did not start conversion")

endmodule

`default_nettype wire

FILE: sv/ptl_back.sv
// ----------------------------------------------------------------------------
// ptl_back
// Incremental PI step, peak tracking and the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ptl_back
    import ptl_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cfg_t                  cfg,
    input  wire queue_status_t         q_status,
    input  wire logic [TEMP_BITS-1:0]  q_pop_data,
    output      logic                  q_pop,
    output      logic                  m_valid,
    input  wire logic                  m_ready,
    output      logic [DUTY_BITS-1:0]  m_pwm_duty,
    output      logic [TEMP_BITS-1:0]  m_temperature,
    output      logic [TEMP_BITS-1:0]  m_max_temperature,
    output      logic [ERR_BITS-1:0]   m_control_error
);

    localparam logic B_MUL = 1'b0;
    localparam logic B_ACC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg;

    logic signed [31:0]         acc_reg;
    logic signed [ERR_BITS-1:0] prev_err_reg;
    logic [TEMP_BITS-1:0]       peak_reg;

    logic [TEMP_BITS-1:0]       t_reg;
    logic signed [ERR_BITS-1:0] e_reg;
    logic signed [15:0]         p0_reg, p1_reg;

    logic [DUTY_BITS-1:0]  duty_reg;
    logic [TEMP_BITS-1:0]  temp_out_reg;
    logic [TEMP_BITS-1:0]  peak_out_reg;
    logic [ERR_BITS-1:0]   err_out_reg;

    logic signed [8:0]          e_wide;
    logic signed [ERR_BITS-1:0] e_next;
    logic signed [15:0]         p0_next, p1_next;
    logic signed [33:0]         sum;
    logic signed [31:0]         acc_next;
    logic [DUTY_BITS-1:0]       duty_next;
    logic [TEMP_BITS-1:0]       peak_next;
    logic                       out_free;
    logic                       commit;

    assign out_free = !out_valid_reg || m_ready;
    assign q_pop    = (state_reg == B_MUL) && !q_status.empty;
    assign commit   = (state_reg == B_ACC) && out_free;

    assign e_wide  = $signed({2'b00, cfg.setpoint}) - $signed({2'b00, q_pop_data});
    assign e_next  = e_wide[ERR_BITS-1:0];
    assign p0_next = cfg.gain_s0 * e_next;
    assign p1_next = cfg.gain_s1 * prev_err_reg;

    assign sum = 34'(acc_reg) + 34'(p0_reg) + 34'(p1_reg);

    always_comb begin
        if (sum > 34'sh0_7FFF_FFFF) begin
            acc_next = 32'sh7FFF_FFFF;
        end else if (sum < -34'sh0_8000_0000) begin
            acc_next = 32'sh8000_0000;
        end else begin
            acc_next = sum[31:0];
        end
        if (sum < 0) begin
            duty_next = '0;
        end else if (sum > 34'(DUTY_MAX)) begin
            duty_next = DUTY_MAX;
        end else begin
            duty_next = sum[DUTY_BITS-1:0];
        end
        peak_next = (t_reg > peak_reg) ? t_reg : peak_reg;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_MUL: begin
                if (!q_status.empty) begin
                    state_next = B_ACC;
                end
            end
            B_ACC: begin
                if (out_free) begin
                    state_next = B_MUL;
                end
            end
            default: state_next = B_MUL;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_MUL;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            prev_err_reg  <= '0;
            peak_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (commit) begin
                out_valid_reg <= 1'b1;
                acc_reg       <= acc_next;
                prev_err_reg  <= e_reg;
                peak_reg      <= peak_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            t_reg  <= q_pop_data;
            e_reg  <= e_next;
            p0_reg <= p0_next;
            p1_reg <= p1_next;
        end
        if (commit) begin
            duty_reg     <= duty_next;
            temp_out_reg <= t_reg;
            peak_out_reg <= peak_next;
            err_out_reg  <= e_reg;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_pwm_duty        = duty_reg;
    assign m_temperature     = temp_out_reg;
    assign m_max_temperature = peak_out_reg;
    assign m_control_error   = err_out_reg;

    `PTL_ASSERT(a_peak_covers_temp, m_valid |-> m_max_temperature >= m_temperature, "peak below temp")
    `PTL_ASSERT(a_negative_acc_zero_duty, (m_valid && acc_reg < 0) |-> m_pwm_duty == '0, "duty set")
    `PTL_ASSERT(a_commit_sets_valid, commit |=> m_valid, "result lost after commit")

endmodule

`default_nettype wire
